// ----- rtl/bbgk_pkg.sv -----
// Shared types and constants for the Bayer binning and green key block.
package bbgk_pkg;

  localparam int PIX_W          = 8;
  localparam int TOL_W          = 7;
  localparam int SW_W           = 13;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 13;
  localparam int MAX_WIDTH_DFLT = 4096;
  localparam int PCT            = 100;

  localparam logic [TOL_W-1:0] TOL_RESET   = '0;
  localparam logic [SW_W-1:0]  WIDTH_RESET = SW_W'(1920);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL   = 1'b0,
    CFG_WIDTH = 1'b1
  } cfg_idx_t;

  // One finished quad as it leaves the line store stage.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] upper_green;
    logic [PIX_W-1:0] lower_green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] plate;
    logic             last;
  } quad_t;

endpackage

// ----- rtl/bbgk_bin.sv -----
// Raster position tracking and line store that gathers each 2x2 quad.
module bbgk_bin #(
  parameter int MAX_WIDTH = bbgk_pkg::MAX_WIDTH_DFLT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         acc,
  input  logic [bbgk_pkg::SW_W-1:0]    src_width,
  input  logic                         frame_start,
  input  logic [bbgk_pkg::PIX_W-1:0]   pix_red,
  input  logic [bbgk_pkg::PIX_W-1:0]   pix_green,
  input  logic [bbgk_pkg::PIX_W-1:0]   pix_blue,
  input  logic [bbgk_pkg::PIX_W-1:0]   plate_green,
  output logic                         quad_valid,
  output bbgk_pkg::quad_t              quad
);

  localparam int STORE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = ((WW > bbgk_pkg::SW_W) ? WW : bbgk_pkg::SW_W) + 1;

  logic [bbgk_pkg::PIX_W-1:0] red_mem [STORE_DEPTH];
  logic [bbgk_pkg::PIX_W-1:0] grn_mem [STORE_DEPTH];

  logic [CW-1:0]              col_r, col_nxt, col_cur;
  logic                       odd_r, odd_nxt, odd_cur;
  logic [bbgk_pkg::PIX_W-1:0] held_r, held_nxt;
  logic [XW-1:0]              w_eff, sw_x, col_x;
  logic [CW-1:0]              col_half;
  logic [AW-1:0]              slot;
  logic                       last;
  logic                       is_result;

  logic                       s1_valid_r;
  logic [bbgk_pkg::PIX_W-1:0] red_rd_r, grn_rd_r;
  logic [bbgk_pkg::PIX_W-1:0] s1_lowg_r, s1_blue_r, s1_plate_r;
  logic                       s1_last_r;

  always_comb begin
    sw_x = XW'(src_width);
    if (sw_x < XW'(2)) begin
      w_eff = XW'(2);
    end else if (sw_x > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = sw_x;
    end
    w_eff[0] = 1'b0;

    col_cur   = frame_start ? '0 : col_r;
    odd_cur   = frame_start ? 1'b0 : odd_r;
    col_x     = XW'(col_cur);
    last      = (col_x + XW'(1)) >= w_eff;
    col_half  = col_cur >> 1;
    slot      = AW'(col_half);
    is_result = odd_cur && col_cur[0];

    col_nxt  = col_r;
    odd_nxt  = odd_r;
    held_nxt = held_r;
    if (acc) begin
      if (last) begin
        col_nxt = '0;
        odd_nxt = ~odd_cur;
      end else begin
        col_nxt = col_cur + CW'(1);
        odd_nxt = odd_cur;
      end
      if (odd_cur && !col_cur[0]) begin
        held_nxt = pix_green;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      odd_r  <= 1'b0;
      held_r <= '0;
    end else begin
      col_r  <= col_nxt;
      odd_r  <= odd_nxt;
      held_r <= held_nxt;
    end
  end

  // Even rows fill the store: red on even columns, upper green on odd ones.
  always_ff @(posedge clk) begin
    if (acc && !odd_cur && !col_cur[0]) begin
      red_mem[slot] <= pix_red;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !odd_cur && col_cur[0]) begin
      grn_mem[slot] <= pix_green;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_result) begin
      red_rd_r <= red_mem[slot];
      grn_rd_r <= grn_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc && is_result;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lowg_r  <= held_r;
      s1_blue_r  <= pix_blue;
      s1_plate_r <= plate_green;
      s1_last_r  <= last;
    end
  end

  assign quad_valid       = s1_valid_r;
  assign quad.red         = red_rd_r;
  assign quad.upper_green = grn_rd_r;
  assign quad.lower_green = s1_lowg_r;
  assign quad.blue        = s1_blue_r;
  assign quad.plate       = s1_plate_r;
  assign quad.last        = s1_last_r;

endmodule

// ----- rtl/bbgk_key.sv -----
// Green average, key band products and compare, and the result register.
module bbgk_key (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [bbgk_pkg::TOL_W-1:0]   tol,
  input  logic                         quad_valid,
  input  bbgk_pkg::quad_t              quad,
  output logic                         out_valid,
  output logic [bbgk_pkg::PIX_W-1:0]   out_red,
  output logic [bbgk_pkg::PIX_W-1:0]   out_green,
  output logic [bbgk_pkg::PIX_W-1:0]   out_blue,
  output logic                         out_opaque,
  output logic                         out_end_of_row
);

  localparam int PW = bbgk_pkg::PIX_W;
  localparam int GW = 15;  // 100 * 255
  localparam int HW = 16;  // 227 * 255

  logic [PW:0]            gsum;
  logic [PW-1:0]          grn;
  logic [GW-1:0]          g100;
  logic                   lo_open;
  logic [PW-1:0]          lo_fac, hi_fac;
  logic [GW-1:0]          lo_prod;
  logic [HW-1:0]          hi_prod;

  logic                   s2_valid_r;
  logic [PW-1:0]          s2_red_r, s2_grn_r, s2_blue_r;
  logic [GW-1:0]          s2_g100_r, s2_lo_r;
  logic [HW-1:0]          s2_hi_r;
  logic                   s2_lo_open_r, s2_pnz_r, s2_last_r;

  logic                   keyed;
  logic                   out_valid_r;
  logic [PW-1:0]          out_red_r, out_grn_r, out_blue_r;
  logic                   out_opaque_r, out_eor_r;

  always_comb begin
    gsum = {1'b0, quad.upper_green} + {1'b0, quad.lower_green};
    grn  = gsum[PW:1];
    g100 = {1'b0, grn, 6'b0} + {2'b0, grn, 5'b0} + {5'b0, grn, 2'b0};
    // Tolerance above 100 makes the lower bound negative: always met.
    lo_open = tol > bbgk_pkg::TOL_W'(bbgk_pkg::PCT);
    lo_fac  = PW'(bbgk_pkg::PCT) - PW'(tol);
    hi_fac  = PW'(bbgk_pkg::PCT) + PW'(tol);
    lo_prod = GW'(lo_fac) * GW'(quad.plate);
    hi_prod = HW'(hi_fac) * HW'(quad.plate);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= quad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_red_r     <= quad.red;
      s2_grn_r     <= grn;
      s2_blue_r    <= quad.blue;
      s2_g100_r    <= g100;
      s2_lo_r      <= lo_prod;
      s2_hi_r      <= hi_prod;
      s2_lo_open_r <= lo_open;
      s2_pnz_r     <= |quad.plate;
      s2_last_r    <= quad.last;
    end
  end

  assign keyed = s2_pnz_r && (s2_grn_r > s2_red_r) &&
                 (s2_lo_open_r || (s2_g100_r >= s2_lo_r)) &&
                 (HW'(s2_g100_r) <= s2_hi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_r    <= keyed ? '0 : s2_red_r;
      out_grn_r    <= keyed ? '0 : s2_grn_r;
      out_blue_r   <= keyed ? '0 : s2_blue_r;
      out_opaque_r <= ~keyed;
      out_eor_r    <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_grn_r;
  assign out_blue       = out_blue_r;
  assign out_opaque     = out_opaque_r;
  assign out_end_of_row = out_eor_r;

endmodule

// ----- rtl/bayer_bin_and_green_key.sv -----
// Top level: 2x2 RGGB binning with green chroma key, config registers and stall control.
//
//   channel | direction | handshake             | words
//   in_     | input     | in_valid / in_ready   | one source pixel each
//   out_    | output    | out_valid / out_ready | one binned pixel per 2x2 quad
//   cfg_    | input     | cfg_we                | tolerance, source width
//
// One source pixel is taken every clock while the output is not stalled. A binned pixel
// is registered in turn from the edge that takes its bottom right pixel: line store read,
// key products, compare. The line store is written and read at one port per cycle, one
// pixel at a time. Reset clears position, held green, pipeline valids and config; the
// store is not cleared, and in_ready is low during reset. A stalled output freezes the
// whole pipeline, and in_ready drops with it.
module bayer_bin_and_green_key #(
  parameter int MAX_WIDTH = bbgk_pkg::MAX_WIDTH_DFLT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_frame_start,
  input  logic [bbgk_pkg::PIX_W-1:0]        in_pix_red,
  input  logic [bbgk_pkg::PIX_W-1:0]        in_pix_green,
  input  logic [bbgk_pkg::PIX_W-1:0]        in_pix_blue,
  input  logic [bbgk_pkg::PIX_W-1:0]        in_plate_green,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bbgk_pkg::PIX_W-1:0]        out_red,
  output logic [bbgk_pkg::PIX_W-1:0]        out_green,
  output logic [bbgk_pkg::PIX_W-1:0]        out_blue,
  output logic                              out_opaque,
  output logic                              out_end_of_row,
  input  logic                              cfg_we,
  input  logic [bbgk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbgk_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [bbgk_pkg::TOL_W-1:0] tol_r;
  logic [bbgk_pkg::SW_W-1:0]  width_r;
  logic                       adv, acc;
  logic                       quad_valid;
  bbgk_pkg::quad_t            quad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= bbgk_pkg::TOL_RESET;
      width_r <= bbgk_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (bbgk_pkg::cfg_idx_t'(cfg_index))
        bbgk_pkg::CFG_TOL:   tol_r   <= cfg_data[bbgk_pkg::TOL_W-1:0];
        bbgk_pkg::CFG_WIDTH: width_r <= cfg_data[bbgk_pkg::SW_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the result register is empty or being drained.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && rst_n;
  assign acc      = in_valid && in_ready;

  bbgk_bin #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_bin (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .acc         (acc),
    .src_width   (width_r),
    .frame_start (in_frame_start),
    .pix_red     (in_pix_red),
    .pix_green   (in_pix_green),
    .pix_blue    (in_pix_blue),
    .plate_green (in_plate_green),
    .quad_valid  (quad_valid),
    .quad        (quad)
  );

  bbgk_key u_key (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .tol            (tol_r),
    .quad_valid     (quad_valid),
    .quad           (quad),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_opaque     (out_opaque),
    .out_end_of_row (out_end_of_row)
  );

endmodule
